// ----- src/assert_macros.svh -----
// Assertion macros shared by the frame rotation engine RTL.
// FRE_ASSERT expects a clock named clk and a reset named rst in scope; FRE_ASSERT_RST needs only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define FRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define FRE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fre_pkg.sv -----
// Package for the frame rotation engine: field widths, codes, payload types
// and the CORDIC arctangent table. No dependencies.
package fre_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int ANGLE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CFG_INDEX_W    = 4;
  localparam int CFG_DATA_W     = 32;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_W     = 34;
  localparam int N_ANGLES     = 5;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // transform kinds
  localparam logic [1:0] KIND_ANT_TO_BODY = 2'd0;
  localparam logic [1:0] KIND_BODY_TO_ANT = 2'd1;
  localparam logic [1:0] KIND_BODY_TO_NED = 2'd2;
  localparam logic [1:0] KIND_NED_TO_BODY = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_AZIMUTH = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_TILT    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_OFF_X   = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_OFF_Y   = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MOUNT_OFF_Z   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ATT_YAW       = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ATT_PITCH     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ATT_ROLL      = 4'd7;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
  } item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;
  } result_t;

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] az;
    logic [ANGLE_WIDTH-1:0] tilt;
    logic [ANGLE_WIDTH-1:0] yaw;
    logic [ANGLE_WIDTH-1:0] pitch;
    logic [ANGLE_WIDTH-1:0] roll;
  } angles_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } offsets_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic [1:0]                 quad;
    logic [2:0]                 slot;
  } cordic_t;

  // atan(2^-i) as a 32-bit turn fraction
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
    logic signed [CORDIC_W-1:0] a;
    case (step)
      0:       a = 34'sd536870912;
      1:       a = 34'sd316933406;
      2:       a = 34'sd167458907;
      3:       a = 34'sd85004756;
      4:       a = 34'sd42667331;
      5:       a = 34'sd21354465;
      6:       a = 34'sd10679838;
      7:       a = 34'sd5340245;
      8:       a = 34'sd2670163;
      9:       a = 34'sd1335087;
      10:      a = 34'sd667544;
      11:      a = 34'sd333772;
      12:      a = 34'sd166886;
      13:      a = 34'sd83443;
      14:      a = 34'sd41722;
      15:      a = 34'sd20861;
      16:      a = 34'sd10430;
      17:      a = 34'sd5215;
      18:      a = 34'sd2608;
      19:      a = 34'sd1304;
      20:      a = 34'sd652;
      21:      a = 34'sd326;
      22:      a = 34'sd163;
      23:      a = 34'sd81;
      24:      a = 34'sd41;
      25:      a = 34'sd20;
      26:      a = 34'sd10;
      27:      a = 34'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/fre_cordic_cell.sv -----
// One CORDIC rotation iteration, registered; cells are chained in a row.
// Depends on fre_pkg (cordic_t, atan_turn).
module fre_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  fre_pkg::cordic_t in_data,
  output logic            out_valid,
  output fre_pkg::cordic_t out_data
);

  localparam int CW = fre_pkg::CORDIC_W;
  localparam logic signed [CW-1:0] ATAN = fre_pkg::atan_turn(STEP);

  logic signed [CW-1:0] x, y, z, dx, dy;

  assign x  = in_data.x;
  assign y  = in_data.y;
  assign z  = in_data.z;
  assign dx = y >>> STEP;
  assign dy = x >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data.quad <= in_data.quad;
    out_data.slot <= in_data.slot;
    if (!z[CW-1]) begin
      out_data.x <= x - dx;
      out_data.y <= y + dy;
      out_data.z <= z - ATAN;
    end else begin
      out_data.x <= x + dx;
      out_data.y <= y - dy;
      out_data.z <= z + ATAN;
    end
  end

endmodule

// ----- src/fre_coef_unit.sv -----
// Coefficient unit: sine/cosine of the five angles through a row of CORDIC
// cells, then the mount and attitude matrices by a sequential multiply-add.
// Depends on fre_pkg, fre_cordic_cell and assert_macros.svh.
`include "assert_macros.svh"

module fre_coef_unit #(
  parameter int COEF_FRAC_BITS = fre_pkg::COEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           recompute,
  input  fre_pkg::angles_t               angles,
  output logic                           busy,
  output logic signed [COEF_FRAC_BITS+1:0] mat_m [9],
  output logic signed [COEF_FRAC_BITS+1:0] mat_n [9]
);

  localparam int CF    = COEF_FRAC_BITS;
  localparam int CWID  = CF + 2;
  localparam int ACC_W = 2 * CWID + 2;
  localparam int CW_C  = fre_pkg::CORDIC_W;
  localparam int AW    = fre_pkg::ANGLE_WIDTH;
  localparam int STEPS = fre_pkg::CORDIC_STEPS;

  localparam logic [2:0] FEED_END  = 3'(fre_pkg::N_ANGLES);
  localparam logic [2:0] LAST_SLOT = 3'(fre_pkg::N_ANGLES - 1);

  localparam logic signed [CWID-1:0] ONE = {2'b01, {CF{1'b0}}};
  localparam logic signed [CW_C-1:0] RND_C =
    {{(CW_C - 30 + CF){1'b0}}, 1'b1, {(29 - CF){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND_M = {{(ACC_W - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [1:0] PH_M = 2'd0;
  localparam logic [1:0] PH_T = 2'd1;
  localparam logic [1:0] PH_N = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_CORDIC = 3'b010,
    S_MUL    = 3'b100
  } state_t;

  function automatic logic signed [CWID-1:0] sat_coef(input logic signed [63:0] v);
    logic signed [63:0] lim;
    lim = 64'(ONE);
    if (v > lim) return ONE;
    if (v < -lim) return -ONE;
    return v[CWID-1:0];
  endfunction

  function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
    return ({2'b00, r} << 1) + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic logic signed [CWID-1:0] rot_elem(
    input logic [1:0] axis,
    input logic signed [CWID-1:0] c,
    input logic signed [CWID-1:0] s,
    input logic [1:0] r,
    input logic [1:0] col
  );
    logic signed [CWID-1:0] e;
    e = '0;
    case (axis)
      AX_Z: begin
        case ({r, col})
          4'b0000: e = c;
          4'b0001: e = -s;
          4'b0100: e = s;
          4'b0101: e = c;
          4'b1010: e = ONE;
          default: e = '0;
        endcase
      end
      AX_Y: begin
        case ({r, col})
          4'b0000: e = c;
          4'b0010: e = s;
          4'b0101: e = ONE;
          4'b1000: e = -s;
          4'b1010: e = c;
          default: e = '0;
        endcase
      end
      AX_X: begin
        case ({r, col})
          4'b0000: e = ONE;
          4'b0101: e = c;
          4'b0110: e = -s;
          4'b1001: e = s;
          4'b1010: e = c;
          default: e = '0;
        endcase
      end
      default: e = '0;
    endcase
    return e;
  endfunction

  state_t     state;
  logic       dirty;
  logic [2:0] feed_cnt;
  logic [1:0] i, j, k, phase;

  logic signed [ACC_W-1:0] acc;
  logic signed [CWID-1:0]  cos_q [fre_pkg::N_ANGLES];
  logic signed [CWID-1:0]  sin_q [fre_pkg::N_ANGLES];
  logic signed [CWID-1:0]  t_mat [9];

  // CORDIC row
  fre_pkg::cordic_t row_d   [STEPS+1];
  logic             row_vld [STEPS+1];

  logic [AW-1:0] ang;
  logic [31:0]   turn;

  always_comb begin
    case (feed_cnt)
      3'd0:    ang = angles.az;
      3'd1:    ang = angles.tilt;
      3'd2:    ang = angles.yaw;
      3'd3:    ang = angles.pitch;
      default: ang = angles.roll;
    endcase
  end

  assign turn          = {ang, {(32 - AW){1'b0}}};
  assign row_d[0].x    = fre_pkg::CORDIC_GAIN;
  assign row_d[0].y    = '0;
  assign row_d[0].z    = {{(CW_C - 30){1'b0}}, turn[29:0]};
  assign row_d[0].quad = turn[31:30];
  assign row_d[0].slot = feed_cnt;
  assign row_vld[0]    = (state == S_CORDIC) && (feed_cnt != FEED_END);

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    fre_cordic_cell #(
      .STEP(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (row_vld[g]),
      .in_data  (row_d[g]),
      .out_valid(row_vld[g+1]),
      .out_data (row_d[g+1])
    );
  end

  // round and unfold quadrant
  logic signed [CW_C-1:0] xs, ys, xr, yr;
  logic signed [CWID-1:0] cc, ss, c_res, s_res;

  assign xs = row_d[STEPS].x + RND_C;
  assign ys = row_d[STEPS].y + RND_C;
  assign xr = xs >>> (30 - CF);
  assign yr = ys >>> (30 - CF);
  assign cc = sat_coef(64'(xr));
  assign ss = sat_coef(64'(yr));

  always_comb begin
    case (row_d[STEPS].quad)
      2'd0:    begin c_res = cc;  s_res = ss;  end
      2'd1:    begin c_res = -ss; s_res = cc;  end
      2'd2:    begin c_res = -cc; s_res = -ss; end
      default: begin c_res = ss;  s_res = -cc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (row_vld[STEPS]) begin
      cos_q[row_d[STEPS].slot] <= c_res;
      sin_q[row_d[STEPS].slot] <= s_res;
    end
  end

  // matrix multiply-add
  logic signed [CWID-1:0]   a_el, b_el, ent;
  logic signed [2*CWID-1:0] prod;
  logic signed [ACC_W-1:0]  sum, rounded;
  logic [3:0]               e_ik, e_ij;

  assign e_ik = idx3(i, k);
  assign e_ij = idx3(i, j);

  always_comb begin
    case (phase)
      PH_M: begin
        a_el = rot_elem(AX_Z, cos_q[0], sin_q[0], i, k);
        b_el = rot_elem(AX_Y, cos_q[1], sin_q[1], k, j);
      end
      PH_T: begin
        a_el = rot_elem(AX_Z, cos_q[2], sin_q[2], i, k);
        b_el = rot_elem(AX_Y, cos_q[3], sin_q[3], k, j);
      end
      default: begin
        a_el = t_mat[e_ik];
        b_el = rot_elem(AX_X, cos_q[4], sin_q[4], k, j);
      end
    endcase
  end

  assign prod    = a_el * b_el;
  assign sum     = acc + ACC_W'(prod);
  assign rounded = (sum + RND_M) >>> CF;
  assign ent     = sat_coef(64'(rounded));

  always_ff @(posedge clk) begin
    if (state == S_MUL && k == 2'd2) begin
      case (phase)
        PH_M:    mat_m[e_ij] <= ent;
        PH_T:    t_mat[e_ij] <= ent;
        default: mat_n[e_ij] <= ent;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      dirty    <= 1'b1;
      feed_cnt <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
      phase    <= PH_M;
      acc      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (dirty) begin
            state    <= S_CORDIC;
            dirty    <= 1'b0;
            feed_cnt <= '0;
          end
        end
        S_CORDIC: begin
          if (feed_cnt != FEED_END) feed_cnt <= feed_cnt + 3'd1;
          if (row_vld[STEPS] && row_d[STEPS].slot == LAST_SLOT) begin
            state <= S_MUL;
            i     <= '0;
            j     <= '0;
            k     <= '0;
            phase <= PH_M;
            acc   <= '0;
          end
        end
        S_MUL: begin
          if (k == 2'd2) begin
            acc <= '0;
            k   <= '0;
            if (j == 2'd2) begin
              j <= '0;
              if (i == 2'd2) begin
                i <= '0;
                if (phase == PH_N) state <= S_IDLE;
                else phase <= phase + 2'd1;
              end else begin
                i <= i + 2'd1;
              end
            end else begin
              j <= j + 2'd1;
            end
          end else begin
            acc <= sum;
            k   <= k + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (recompute) dirty <= 1'b1;
    end
  end

  assign busy = (state != S_IDLE) || dirty;

  `FRE_ASSERT_RST(a_reset_recompute, rst |=> busy, "no coefficient pass after reset")
  `FRE_ASSERT(a_cordic_in_phase, row_vld[STEPS] |-> state == S_CORDIC, "stray CORDIC result")
  `FRE_ASSERT(a_mul_start, $rose(state == S_MUL) |-> (phase == PH_M && i == 2'd0 && j == 2'd0 && k == 2'd0), "matrix pass starts mid-sequence")

endmodule

// ----- src/fre_vec_pipe.sv -----
// Vector datapath: pre-transform, 3x3 coefficient product, rounding and
// offset/axis fix-up with saturation. Four stages. Depends on fre_pkg.
module fre_vec_pipe #(
  parameter int COEF_FRAC_BITS = fre_pkg::COEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  output logic                             ready,
  input  fre_pkg::item_t                   item,
  input  fre_pkg::offsets_t                offs,
  input  logic signed [COEF_FRAC_BITS+1:0] mat_m [9],
  input  logic signed [COEF_FRAC_BITS+1:0] mat_n [9],
  output logic                             result_valid,
  input  logic                             result_stall,
  output fre_pkg::result_t                 result
);

  localparam int CW   = fre_pkg::COORD_WIDTH;
  localparam int CF   = COEF_FRAC_BITS;
  localparam int CWID = CF + 2;
  localparam int W    = CW + 1;
  localparam int P    = W + CWID;
  localparam int S    = P + 2;
  localparam int R    = CW + 5;
  localparam int Q    = CW + 6;

  localparam logic signed [S-1:0] RND = {{(S - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4   = !v4 || !result_stall;
  assign en3   = !v3 || en4;
  assign en2   = !v2 || en3;
  assign en1   = !v1 || en2;
  assign ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= take;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  assign result_valid = v4;

  // stage 1: axis remap or offset removal
  logic signed [W-1:0] ix, iy, iz, ox, oy, oz;
  logic signed [W-1:0] w_in [3];
  logic signed [W-1:0] w1 [3];
  logic [1:0]          kind1, kind2, kind3;

  assign ix = {item.in_x[CW-1], item.in_x};
  assign iy = {item.in_y[CW-1], item.in_y};
  assign iz = {item.in_z[CW-1], item.in_z};
  assign ox = {offs.x[CW-1], offs.x};
  assign oy = {offs.y[CW-1], offs.y};
  assign oz = {offs.z[CW-1], offs.z};

  always_comb begin
    case (item.kind)
      fre_pkg::KIND_ANT_TO_BODY: begin
        w_in[0] = iz;
        w_in[1] = -ix;
        w_in[2] = -iy;
      end
      fre_pkg::KIND_BODY_TO_ANT: begin
        w_in[0] = ix - ox;
        w_in[1] = iy - oy;
        w_in[2] = iz - oz;
      end
      default: begin
        w_in[0] = ix;
        w_in[1] = iy;
        w_in[2] = iz;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en1 && take) begin
      w1    <= w_in;
      kind1 <= item.kind;
    end
  end

  // stage 2: nine products
  logic signed [CWID-1:0] csel [3][3];
  logic signed [P-1:0]    p2 [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        case (kind1)
          fre_pkg::KIND_ANT_TO_BODY: csel[r][c] = mat_m[r*3 + c];
          fre_pkg::KIND_BODY_TO_ANT: csel[r][c] = mat_m[c*3 + r];
          fre_pkg::KIND_BODY_TO_NED: csel[r][c] = mat_n[r*3 + c];
          default:                   csel[r][c] = mat_n[c*3 + r];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      kind2 <= kind1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p2[r][c] <= csel[r][c] * w1[c];
        end
      end
    end
  end

  // stage 3: row sums, rounded once
  logic signed [S-1:0] sum3 [3];
  logic signed [S-1:0] sh3 [3];
  logic signed [R-1:0] r3 [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum3[r] = S'(p2[r][0]) + S'(p2[r][1]) + S'(p2[r][2]) + RND;
      sh3[r]  = sum3[r] >>> CF;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      kind3 <= kind2;
      for (int r = 0; r < 3; r++) begin
        r3[r] <= sh3[r][R-1:0];
      end
    end
  end

  // stage 4: offset add or inverse remap, then saturation
  logic signed [Q-1:0]  rx [3];
  logic signed [Q-1:0]  q [3];
  logic signed [CW-1:0] o [3];
  logic [2:0]           clip;
  logic [Q-CW:0]        top;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rx[r] = {r3[r][R-1], r3[r]};
    end
    case (kind3)
      fre_pkg::KIND_ANT_TO_BODY: begin
        q[0] = rx[0] + Q'(offs.x);
        q[1] = rx[1] + Q'(offs.y);
        q[2] = rx[2] + Q'(offs.z);
      end
      fre_pkg::KIND_BODY_TO_ANT: begin
        q[0] = -rx[1];
        q[1] = -rx[2];
        q[2] = rx[0];
      end
      default: begin
        q[0] = rx[0];
        q[1] = rx[1];
        q[2] = rx[2];
      end
    endcase
    top = '0;
    for (int r = 0; r < 3; r++) begin
      top = q[r][Q-1:CW-1];
      clip[r] = !((&top) || !(|top));
      if (!clip[r]) o[r] = q[r][CW-1:0];
      else if (q[r][Q-1]) o[r] = {1'b1, {(CW - 1){1'b0}}};
      else o[r] = {1'b0, {(CW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      result.out_x     <= o[0];
      result.out_y     <= o[1];
      result.out_z     <= o[2];
      result.saturated <= |clip;
    end
  end

endmodule

// ----- src/frame_rotation_engine.sv -----
// Frame rotation engine: transforms a Q23.8 3-D vector between antenna,
// body and NED frames. Kind 0 maps antenna to body (axis remap, mount tilt
// about y, mount azimuth about z, plus mount offset); kind 1 is its inverse;
// kind 2 rotates body to NED by roll, pitch and yaw; kind 3 is the inverse.
// Results saturate to 32 bits and raise the saturated flag. Throughput is
// one vector per cycle while item_stall is low; output stalls back up
// through the four stages of the vector pipeline, and bubbles in them
// still let items in. After reset and after every register write the
// coefficient unit recomputes both matrices: five angles pass a row of 28
// CORDIC cells, then 81 multiply-add steps on one multiplier build the
// matrices, during which item_stall stays high. Register writes are always
// ready and take effect on the next vectors, and can reach those in flight.
// Depends on fre_pkg, fre_coef_unit, fre_vec_pipe and assert_macros.svh.
`include "assert_macros.svh"

module frame_rotation_engine #(
  parameter int COEF_FRAC_BITS = fre_pkg::COEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  // item channel
  input  logic                               item_valid,
  output logic                               item_stall,
  input  fre_pkg::item_t                     item,
  // result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output fre_pkg::result_t                   result,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fre_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = fre_pkg::COORD_WIDTH;
  localparam int AW = fre_pkg::ANGLE_WIDTH;

  fre_pkg::angles_t  angles;
  fre_pkg::offsets_t offs;

  logic cfg_write;
  logic coef_busy;
  logic pipe_ready;
  logic take;

  logic signed [COEF_FRAC_BITS+1:0] mat_m [9];
  logic signed [COEF_FRAC_BITS+1:0] mat_n [9];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      angles <= '0;
      offs   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        fre_pkg::REG_MOUNT_AZIMUTH: angles.az    <= cfg_data[AW-1:0];
        fre_pkg::REG_MOUNT_TILT:    angles.tilt  <= cfg_data[AW-1:0];
        fre_pkg::REG_MOUNT_OFF_X:   offs.x       <= cfg_data[CW-1:0];
        fre_pkg::REG_MOUNT_OFF_Y:   offs.y       <= cfg_data[CW-1:0];
        fre_pkg::REG_MOUNT_OFF_Z:   offs.z       <= cfg_data[CW-1:0];
        fre_pkg::REG_ATT_YAW:       angles.yaw   <= cfg_data[AW-1:0];
        fre_pkg::REG_ATT_PITCH:     angles.pitch <= cfg_data[AW-1:0];
        fre_pkg::REG_ATT_ROLL:      angles.roll  <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // hold items off while the pipeline cannot advance or the matrices are stale or being rebuilt
  assign item_stall = !pipe_ready || coef_busy || cfg_valid;
  assign take       = item_valid && !item_stall;

  fre_coef_unit #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_coef (
    .clk      (clk),
    .rst      (rst),
    .recompute(cfg_write),
    .angles   (angles),
    .busy     (coef_busy),
    .mat_m    (mat_m),
    .mat_n    (mat_n)
  );

  fre_vec_pipe #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .ready       (pipe_ready),
    .item        (item),
    .offs        (offs),
    .mat_m       (mat_m),
    .mat_n       (mat_n),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  `FRE_ASSERT(a_cfg_blocks_items, cfg_write |=> item_stall, "item taken right after a register write")
  `FRE_ASSERT(a_no_take_when_busy, take |-> !coef_busy, "item taken while coefficients rebuild")

endmodule

// ----- dv/frame_rotation_engine_test.sv -----
// Self-checking testbench for frame_rotation_engine: random and directed
// vectors against a fixed-point frame transform predictor held in a scoreboard.
// Depends on fre_pkg and the engine RTL.
`timescale 1ns / 100ps

module frame_rotation_engine_test;
  import fre_pkg::*;

  typedef longint mat3_t [3][3];
  typedef longint vec3_t [3];

  localparam int  ITEMS_PER_PHASE = 320;
  localparam int  N_PHASES        = 6;
  localparam int  LIMIT_CYCLES    = 400000;
  localparam int  IDLE_PCT        = 31;
  // rotation axes for the predictor
  localparam int  AXIS_X          = 0;
  localparam int  AXIS_Y          = 1;
  localparam int  AXIS_Z          = 2;
  // an index past the register list: the write must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 4'd12;

  // Scoreboard: shadow registers, transform predictor and pending results
  class frame_scoreboard;
    logic [ANGLE_WIDTH-1:0]       ang [8];
    logic signed [COORD_WIDTH-1:0] offs [3];
    result_t pending[$];
    int mismatches;
    int checked;

    function new();
      for (int i = 0; i < 8; i++) ang[i] = '0;
      for (int i = 0; i < 3; i++) offs[i] = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx >= REG_MOUNT_OFF_X && idx <= REG_MOUNT_OFF_Z)
        offs[idx - REG_MOUNT_OFF_X] = data[COORD_WIDTH-1:0];
      else if (idx <= REG_ATT_ROLL)
        ang[idx] = data[ANGLE_WIDTH-1:0];
    endfunction

    function longint clamp_coef(longint v);
      longint one;
      one = longint'(1) << COEF_FRAC_BITS;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
    endfunction

    // CORDIC on the low 30 bits of the turn fraction, quadrant fixed afterwards
    function void sin_cos(logic [ANGLE_WIDTH-1:0] a, output longint c, output longint s);
      longint arctan [28] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                               21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                               333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                               1304, 652, 326, 163, 81, 41, 20, 10, 5};
      logic [31:0] turn;
      longint x, y, z, dx, dy, cc, ss;
      turn = {a, {(32-ANGLE_WIDTH){1'b0}}};
      x = 652032874;
      y = 0;
      z = longint'(turn[29:0]);
      for (int i = 0; i < 28; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan[i];
        end else begin
          x += dx; y -= dy; z += arctan[i];
        end
      end
      cc = clamp_coef((x + (longint'(1) << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS));
      ss = clamp_coef((y + (longint'(1) << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS));
      case (turn[31:30])
        2'd0: begin c = cc;  s = ss;  end
        2'd1: begin c = -ss; s = cc;  end
        2'd2: begin c = -cc; s = -ss; end
        default: begin c = ss; s = -cc; end
      endcase
    endfunction

    function void rotation(int axis, logic [ANGLE_WIDTH-1:0] a, output mat3_t m);
      longint c, s, one;
      one = longint'(1) << COEF_FRAC_BITS;
      sin_cos(a, c, s);
      case (axis)
        AXIS_X: m = '{'{one, 0, 0}, '{0, c, -s}, '{0, s, c}};
        AXIS_Y: m = '{'{c, 0, s}, '{0, one, 0}, '{-s, 0, c}};
        default: m = '{'{c, -s, 0}, '{s, c, 0}, '{0, 0, one}};
      endcase
    endfunction

    function void mat_product(mat3_t a, mat3_t b, output mat3_t r);
      longint acc;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
          r[i][j] = clamp_coef((acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
        end
    endfunction

    // single rounding of the exact sum
    function void apply(mat3_t m, bit transposed, vec3_t v, output vec3_t o);
      longint acc;
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += (transposed ? m[k][i] : m[i][k]) * v[k];
        o[i] = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      end
    endfunction

    function logic signed [COORD_WIDTH-1:0] saturate(longint v, inout logic flag);
      longint hi, lo;
      hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin v = hi; flag = 1'b1; end
      if (v < lo) begin v = lo; flag = 1'b1; end
      return v[COORD_WIDTH-1:0];
    endfunction

    function void note_item(item_t it);
      mat3_t a, b, m, n;
      vec3_t v, w, r;
      result_t res;
      logic flag;
      flag = 1'b0;
      v[0] = it.in_x;
      v[1] = it.in_y;
      v[2] = it.in_z;
      case (it.kind)
        KIND_ANT_TO_BODY, KIND_BODY_TO_ANT: begin
          rotation(AXIS_Z, ang[REG_MOUNT_AZIMUTH], a);
          rotation(AXIS_Y, ang[REG_MOUNT_TILT], b);
          mat_product(a, b, m);
          if (it.kind == KIND_ANT_TO_BODY) begin
            w = '{v[2], -v[0], -v[1]};
            apply(m, 1'b0, w, r);
            for (int i = 0; i < 3; i++) r[i] += offs[i];
          end else begin
            for (int i = 0; i < 3; i++) w[i] = v[i] - offs[i];
            apply(m, 1'b1, w, v);
            r = '{-v[1], -v[2], v[0]};
          end
        end
        default: begin
          rotation(AXIS_Z, ang[REG_ATT_YAW], a);
          rotation(AXIS_Y, ang[REG_ATT_PITCH], b);
          mat_product(a, b, m);
          rotation(AXIS_X, ang[REG_ATT_ROLL], a);
          mat_product(m, a, n);
          apply(n, it.kind == KIND_NED_TO_BODY, v, r);
        end
      endcase
      res.out_x = saturate(r[0], flag);
      res.out_y = saturate(r[1], flag);
      res.out_z = saturate(r[2], flag);
      res.saturated = flag;
      pending.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got x=%0d y=%0d z=%0d sat=%0b",
                   want.out_x, want.out_y, want.out_z, want.saturated,
                   got.out_x, got.out_y, got.out_z, got.saturated);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  frame_scoreboard sb;
  bit quiet;          // no idling on either side while set
  int cycles;
  int cfg_writes;
  int sat_seen;

  frame_rotation_engine u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (result.saturated) sat_seen++;
      sb.check_result(result);
    end
    result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    sb.note_item(it);
  endtask

  // each write is followed by an idle gap with cfg_valid low
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
    cfg_writes++;
    @(posedge clk);
  endtask

  // pipeline is four deep; let it empty before touching the registers
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.kind = 2'($urandom_range(0, 3));
    it.in_x = rand_coord();
    it.in_y = rand_coord();
    it.in_z = rand_coord();
    return it;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] angle_set [5];
    logic [CFG_DATA_W-1:0] off_set [3];
    logic signed [COORD_WIDTH-1:0] corner [4];
    item_t it;

    sb = new();
    quiet = 1'b0;
    cycles = 0;
    cfg_writes = 0;
    sat_seen = 0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: every kind on zero, both extremes and a mixed vector,
    // with identity rotations; negating the minimum saturates
    corner = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd256};
    for (int k = 0; k < 4; k++)
      for (int c = 0; c < 4; c++) begin
        it.kind = k[1:0];
        it.in_x = corner[c];
        it.in_y = (c == 3) ? -32'sd1 : corner[c];
        it.in_z = (c == 3) ? 32'sd1 : corner[c];
        send_item(it);
      end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      case (p)
        0: begin  // upper extremes, offsets at the top of range
          angle_set = '{32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF};
          off_set = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        end
        1: begin  // lower extremes, upper bits of angle data must be ignored
          angle_set = '{32'hFFFF_8000, 32'h0001_8000, 32'h8000, 32'hABCD_8000, 32'h8000};
          off_set = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        end
        2: begin  // quadrant boundaries
          angle_set = '{32'h4000, 32'hC000, 32'h4000, 32'hC000, 32'h4000};
          off_set = '{32'd0, 32'd256, -32'sd256};
          quiet = 1'b1;
        end
        default: begin
          foreach (angle_set[i]) angle_set[i] = $urandom();
          foreach (off_set[i]) off_set[i] = (p == 3) ? $urandom() : rand_coord();
          quiet = 1'b0;
        end
      endcase
      write_reg(REG_MOUNT_AZIMUTH, angle_set[0]);
      write_reg(REG_MOUNT_TILT, angle_set[1]);
      write_reg(REG_ATT_YAW, angle_set[2]);
      write_reg(REG_ATT_PITCH, angle_set[3]);
      write_reg(REG_ATT_ROLL, angle_set[4]);
      write_reg(REG_MOUNT_OFF_X, off_set[0]);
      write_reg(REG_MOUNT_OFF_Y, off_set[1]);
      write_reg(REG_MOUNT_OFF_Z, off_set[2]);
      if (p >= 4) write_reg(REG_UNMAPPED, $urandom());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_item(rand_item());
    end

    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d results over %0d register settings (%0d writes), %0d saturated",
             sb.checked, N_PHASES + 1, cfg_writes, sat_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
